// ===== design/gkg_pkg.sv =====
`default_nettype none
package gkg_pkg;

  localparam int KEY_W  = 35;
  localparam int GAP_W  = 5;
  localparam int LEN_W  = 4;
  localparam int SEEN_W = 6;
  localparam int BASE_W = 2;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [SEEN_W-1:0] SEEN_MAX = 6'd63;

  localparam logic [APB_AW-1:0] REG_KMER_ADDR = 3'd0;
  localparam logic [APB_AW-1:0] REG_GAP_ADDR  = 3'd4;

  localparam logic [LEN_W-1:0] KMER_RESET = 4'd10;
  localparam logic [GAP_W-1:0] GAP_RESET  = 5'd0;

  // Per-base control handed from the front to the back with the window copy
  typedef struct packed {
    logic [GAP_W-1:0] last_gap;
    logic             cls;
  } gkg_ctl_t;

endpackage
`default_nettype wire

// ===== design/gkg_front.sv =====
`default_nettype none
module gkg_front #(
  parameter int WW = 92
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      accept,
  input  wire logic [gkg_pkg::BASE_W-1:0] base,
  input  wire logic                      first_of_sequence,
  input  wire logic                      negative_class,
  input  wire logic [gkg_pkg::LEN_W-1:0] len,
  input  wire logic [gkg_pkg::GAP_W-1:0] gmax,
  output logic                           q_push,
  output logic [WW-1:0]                  q_win,
  output gkg_pkg::gkg_ctl_t              q_ctl
);
  import gkg_pkg::*;

  logic [WW-1:0]     win_r;
  logic [WW-1:0]     win_nxt;
  logic [SEEN_W-1:0] seen_r;
  logic [SEEN_W-1:0] seen_nxt;
  logic [SEEN_W-1:0] seen_base;
  logic [SEEN_W-1:0] avail;
  logic              enough;

  always_comb begin
    win_nxt   = {win_r[WW-BASE_W-1:0], base};
    seen_base = first_of_sequence ? '0 : seen_r;
    seen_nxt  = (seen_base < SEEN_MAX) ? seen_base + SEEN_W'(1) : seen_base;
    enough    = seen_nxt >= SEEN_W'(len);
    avail     = seen_nxt - SEEN_W'(len);
  end

  // Classify: how many gaps qualify, expressed as the last gap to emit
  always_comb begin
    q_push       = accept && enough;
    q_win        = win_nxt;
    q_ctl.cls    = negative_class;
    q_ctl.last_gap = (avail >= SEEN_W'(gmax)) ? gmax : avail[GAP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (accept) begin
      seen_r <= seen_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/gkg_queue.sv =====
`default_nettype none
module gkg_queue #(
  parameter int DW = 98
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          pop,
  output logic [DW-1:0]      rdata,
  output logic               full,
  output logic               empty
);

  logic [DW-1:0] mem_r [2];
  logic          wptr_r;
  logic          wptr_nxt;
  logic          rptr_r;
  logic          rptr_nxt;
  logic [1:0]    cnt_r;
  logic [1:0]    cnt_nxt;
  logic          do_push;
  logic          do_pop;

  always_comb begin
    full     = cnt_r == 2'd2;
    empty    = cnt_r == 2'd0;
    do_push  = push && !full;
    do_pop   = pop && !empty;
    wptr_nxt = do_push ? !wptr_r : wptr_r;
    rptr_nxt = do_pop ? !rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    rdata    = mem_r[rptr_r];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/gkg_back.sv =====
`default_nettype none
module gkg_back #(
  parameter int WW = 92,
  parameter int KW = 30
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       q_empty,
  input  wire logic [WW-1:0]              q_win,
  input  wire gkg_pkg::gkg_ctl_t          q_ctl,
  output logic                            q_pop,
  input  wire logic [gkg_pkg::LEN_W-1:0]  len,
  input  wire logic                       pop,
  output logic                            empty,
  output logic [gkg_pkg::KEY_W-1:0]       gapped_key,
  output logic [gkg_pkg::GAP_W-1:0]       gap_length,
  output logic                            key_class,
  output logic                            last_of_run
);
  import gkg_pkg::*;

  logic                 busy_r;
  logic                 busy_nxt;
  logic [WW-1:0]        wsh_r;
  logic [KW-1:0]        lo_r;
  logic [GAP_W-1:0]     g_r;
  logic [GAP_W-1:0]     last_g_r;
  logic                 cls_r;

  logic                 ovalid_r;
  logic                 ovalid_nxt;
  logic [KEY_W-1:0]     okey_r;
  logic [GAP_W-1:0]     ogap_r;
  logic                 ocls_r;
  logic                 olast_r;

  logic [LEN_W-1:0]     lo_n;
  logic [KW-1:0]        mask_all;
  logic [KW-1:0]        mask_lo;
  logic [KW-1:0]        mask_hi;
  logic [KW-1:0]        packed_key;
  logic                 adv;
  logic                 is_last;
  logic                 take;

  // Masks follow the configured length only, so they are static per run
  always_comb begin
    lo_n     = len - (len >> 1);
    mask_all = (KW'(1) << {len, 1'b0}) - KW'(1);
    mask_lo  = (KW'(1) << {lo_n, 1'b0}) - KW'(1);
    mask_hi  = mask_all & ~mask_lo;
  end

  always_comb begin
    packed_key = (wsh_r[KW-1:0] & mask_hi) | lo_r;
    adv        = busy_r && (!ovalid_r || pop);
    is_last    = g_r == last_g_r;
    take       = !q_empty && (!busy_r || (adv && is_last));
    q_pop      = take;
    if (take) begin
      busy_nxt = 1'b1;
    end else if (adv && is_last) begin
      busy_nxt = 1'b0;
    end else begin
      busy_nxt = busy_r;
    end
    if (adv) begin
      ovalid_nxt = 1'b1;
    end else if (pop) begin
      ovalid_nxt = 1'b0;
    end else begin
      ovalid_nxt = ovalid_r;
    end
  end

  // Each step widens the gap by one base: drop the newest base off the copy
  always_ff @(posedge clk) begin
    if (take) begin
      wsh_r    <= q_win;
      lo_r     <= q_win[KW-1:0] & mask_lo;
      g_r      <= '0;
      last_g_r <= q_ctl.last_gap;
      cls_r    <= q_ctl.cls;
    end else if (adv) begin
      wsh_r <= wsh_r >> BASE_W;
      g_r   <= g_r + GAP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      okey_r  <= KEY_W'({packed_key, g_r});
      ogap_r  <= g_r;
      ocls_r  <= cls_r;
      olast_r <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_comb begin
    empty       = !ovalid_r;
    gapped_key  = okey_r;
    gap_length  = ogap_r;
    key_class   = ocls_r;
    last_of_run = olast_r;
  end

endmodule
`default_nettype wire

// ===== design/gapped_kmer_key_generator.sv =====
`default_nettype none
// Gapped k-mer key generator. Push one 2-bit base per word; for every gap g
// from 0 up to max_gap (ascending) for which the current sequence already
// holds kmer_length+g bases, one key word comes out, ordered by end position,
// with last_of_run set on the final key of each base. The back end emits one
// key per cycle, unless the result word waits unpopped, from a private copy
// of the base window. A two-entry queue between the front (window, base
// count, key count) and the back end lets new bases enter while keys are
// still draining, and the result port is a registered word. Bases that
// produce no key never reach the back end. Write configuration only while
// no keys are pending.
module gapped_kmer_key_generator #(
  parameter int MAX_KMER = 15,
  parameter int MAX_GAP  = 31
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [gkg_pkg::BASE_W-1:0]  in_base,
  input  wire logic                        in_first_of_sequence,
  input  wire logic                        in_negative_class,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [gkg_pkg::KEY_W-1:0]        out_gapped_key,
  output logic [gkg_pkg::GAP_W-1:0]        out_gap_length,
  output logic                             out_key_class,
  output logic                             out_last_of_run,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [gkg_pkg::APB_AW-1:0]  paddr,
  input  wire logic [gkg_pkg::APB_DW-1:0]  pwdata,
  output logic [gkg_pkg::APB_DW-1:0]       prdata,
  output logic                             pready
);
  import gkg_pkg::*;

  localparam int WIN_DEPTH = MAX_KMER + MAX_GAP;
  localparam int WW        = BASE_W * WIN_DEPTH;
  localparam int KW        = BASE_W * MAX_KMER;
  localparam int CTL_W     = $bits(gkg_ctl_t);
  localparam int QW        = WW + CTL_W;

  logic [LEN_W-1:0] kmer_r;
  logic [LEN_W-1:0] kmer_nxt;
  logic [GAP_W-1:0] gap_r;
  logic [GAP_W-1:0] gap_nxt;
  logic [LEN_W-1:0] len_c;
  logic [GAP_W-1:0] gmax_c;
  logic             cfg_wr;

  logic             in_accept;
  logic             f_push;
  logic [WW-1:0]    f_win;
  gkg_ctl_t         f_ctl;
  logic [QW-1:0]    q_rdata;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  logic [WW-1:0]    b_win;
  gkg_ctl_t         b_ctl;

  // Configuration registers; any address other than zero hits max_gap
  always_comb begin
    pready   = 1'b1;
    cfg_wr   = psel && penable && pwrite && pready;
    kmer_nxt = kmer_r;
    gap_nxt  = gap_r;
    if (cfg_wr) begin
      if (paddr == REG_KMER_ADDR) begin
        kmer_nxt = pwdata[LEN_W-1:0];
      end else begin
        gap_nxt = pwdata[GAP_W-1:0];
      end
    end
    prdata = (paddr == REG_KMER_ADDR) ? APB_DW'(kmer_r) : APB_DW'(gap_r);
    len_c  = (kmer_r > LEN_W'(MAX_KMER)) ? LEN_W'(MAX_KMER) : kmer_r;
    gmax_c = (gap_r > GAP_W'(MAX_GAP)) ? GAP_W'(MAX_GAP) : gap_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmer_r <= KMER_RESET;
      gap_r  <= GAP_RESET;
    end else begin
      kmer_r <= kmer_nxt;
      gap_r  <= gap_nxt;
    end
  end

  always_comb begin
    full      = q_full;
    in_accept = push && !q_full;
    b_win     = q_rdata[WW-1:0];
    b_ctl     = q_rdata[QW-1:WW];
  end

  gkg_front #(
    .WW (WW)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .accept            (in_accept),
    .base              (in_base),
    .first_of_sequence (in_first_of_sequence),
    .negative_class    (in_negative_class),
    .len               (len_c),
    .gmax              (gmax_c),
    .q_push            (f_push),
    .q_win             (f_win),
    .q_ctl             (f_ctl)
  );

  gkg_queue #(
    .DW (QW)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata ({f_ctl, f_win}),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  gkg_back #(
    .WW (WW),
    .KW (KW)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_win       (b_win),
    .q_ctl       (b_ctl),
    .q_pop       (q_pop),
    .len         (len_c),
    .pop         (pop),
    .empty       (empty),
    .gapped_key  (out_gapped_key),
    .gap_length  (out_gap_length),
    .key_class   (out_key_class),
    .last_of_run (out_last_of_run)
  );

  a_gap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_gap_length <= gmax_c)
    else $error("gap length above configured maximum");

  a_gap_step: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && !out_last_of_run) |=>
      (!empty && out_gap_length == GAP_W'($past(out_gap_length) + GAP_W'(1))))
    else $error("next key of a run missing or out of order");

  a_key_tag: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_gapped_key[GAP_W-1:0] == out_gap_length)
    else $error("key low bits differ from gap length");

endmodule
`default_nettype wire
